/* src/box_filter_3x3_edge_aware_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 edge-aware box filter
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_3X3_EDGE_AWARE_MACROS_SVH
`define BOX_FILTER_3X3_EDGE_AWARE_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define BF3_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bf3 assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define BF3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bf3 assertion failed: next-cycle implication");

`endif

/* src/bf3_pkg.sv */
// ----------------------------------------------------------------------------
// bf3_pkg
// Types and constants shared by the blocks of the 3x3 edge-aware box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

  // Field and datapath widths.
  localparam int FS_W      = 6;   // frame size and position counters
  localparam int PIX_W     = 8;   // one pixel
  localparam int COL_SUM_W = 10;  // sum of up to three pixels of one column
  localparam int SUM_W     = 12;  // sum of up to nine pixels
  localparam int NUM_W     = 13;  // 2*sum + count

  // Smallest legal frame side.
  localparam int MIN_SIZE = 2;

  // Configuration port.
  localparam int PDATA_W = 32;
  localparam int ADDR_W  = 3;
  localparam logic REG_IDX_FRAME_SIZE = 1'b0;

  // Column queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Reciprocals for the constant divides by 3 and by 9.
  localparam int RECIP3    = 683;
  localparam int RECIP3_SH = 11;
  localparam int RECIP9    = 1821;
  localparam int RECIP9_SH = 14;

  // Front sequencer states.
  typedef enum logic {
    FS_STREAM,
    FS_FLUSH
  } front_state_t;

  // Back phase: the last column of a row yields a second result.
  typedef enum logic {
    BP_FIRST,
    BP_SECOND
  } back_phase_t;

  // Neighbor count class of one result.
  typedef enum logic [1:0] {
    DIV4,
    DIV6,
    DIV9
  } div_sel_t;

  // Control bits that travel with one column.
  typedef struct packed {
    logic three_rows;  // column covers rows above, at and below the center
    logic has_left2;   // the column two to the left lies inside the frame
    logic emit;        // this column completes the window of the previous one
    logic last_col;    // last column of the row: a right-edge result follows
    logic run_end;     // final result of this column closes the input's run
    logic eof;         // final result of this column closes the frame
  } tok_ctl_t;

  // One column transaction in the queue.
  typedef struct packed {
    tok_ctl_t               ctl;
    logic [COL_SUM_W-1:0]   col_sum;
  } col_tok_t;

endpackage

/* src/bf3_front.sv */
// ----------------------------------------------------------------------------
// bf3_front
// Accepts pixels, keeps three rows in the line store and turns every
// position into a column sum with its control bits. Runs the final-row
// flush after the last pixel of a frame.
// ----------------------------------------------------------------------------
`include "box_filter_3x3_edge_aware_macros.svh"

module bf3_front #(
  parameter int MAX_SIZE = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_clr,
  input  logic [bf3_pkg::FS_W-1:0]      side,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bf3_pkg::PIX_W-1:0]     in_pixel,
  input  logic [bf3_pkg::Q_CNT_W-1:0]   q_count,
  output logic                          push_valid,
  output bf3_pkg::col_tok_t             push_tok
);
  import bf3_pkg::*;

  localparam int MEM_DEPTH = 3 * MAX_SIZE;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // Row slot helpers: slots rotate 0, 1, 2.
  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  logic [PIX_W-1:0] mem [MEM_DEPTH];

  front_state_t     state_r, state_nxt;
  logic [FS_W-1:0]  row_r, row_nxt;
  logic [FS_W-1:0]  col_r, col_nxt;
  logic [1:0]       slot_r, slot_nxt;
  logic [FS_W-1:0]  fl_col_r, fl_col_nxt;
  logic [1:0]       fl_slot_r, fl_slot_nxt;

  logic             s1_valid_r;
  tok_ctl_t         s1_ctl_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic             s1_use_b_r;
  logic [PIX_W-1:0] rd_a_r;
  logic [PIX_W-1:0] rd_b_r;

  logic             room;
  logic             accept;
  logic             flush_go;
  logic             issue;
  logic [FS_W-1:0]  side_m1;
  logic             at_last_col;
  logic             frame_last;
  logic             fl_last;
  logic [1:0]       rd_slot_a;
  logic [1:0]       rd_slot_b;
  logic [FS_W-1:0]  rd_col;
  logic [MEM_AW-1:0] wr_addr;
  logic [MEM_AW-1:0] rd_addr_a;
  logic [MEM_AW-1:0] rd_addr_b;
  tok_ctl_t         iss_ctl;
  logic [PIX_W-1:0] iss_pix;
  logic             iss_use_b;

  // Issue only when the queue can hold this column and the one in flight.
  assign room = ({1'b0, q_count} + (Q_CNT_W + 1)'(s1_valid_r)) < (Q_CNT_W + 1)'(Q_DEPTH);

  assign in_ready = (state_r == FS_STREAM) && room;
  assign accept   = in_valid && in_ready;
  assign flush_go = (state_r == FS_FLUSH) && room;

  assign side_m1     = side - FS_W'(1);
  assign at_last_col = (col_r == side_m1);
  assign frame_last  = (row_r == side_m1) && at_last_col;
  assign fl_last     = (fl_col_r == side_m1);

  // Row zero only fills the store; every later position yields a column.
  assign issue = (accept && (row_r != '0)) || flush_go;

  // Read addresses and column control for the stream and the flush.
  always_comb begin
    if (state_r == FS_FLUSH) begin
      rd_slot_a          = fl_slot_r;
      rd_slot_b          = slot_dec(fl_slot_r);
      rd_col             = fl_col_r;
      iss_pix            = '0;
      iss_use_b          = 1'b1;
      iss_ctl.three_rows = 1'b0;
      iss_ctl.has_left2  = (fl_col_r >= FS_W'(2));
      iss_ctl.emit       = (fl_col_r != '0);
      iss_ctl.last_col   = fl_last;
      iss_ctl.run_end    = fl_last;
      iss_ctl.eof        = fl_last;
    end else begin
      rd_slot_a          = slot_dec(slot_r);
      rd_slot_b          = slot_dec(slot_dec(slot_r));
      rd_col             = col_r;
      iss_pix            = in_pixel;
      iss_use_b          = (row_r >= FS_W'(2));
      iss_ctl.three_rows = (row_r >= FS_W'(2));
      iss_ctl.has_left2  = (col_r >= FS_W'(2));
      iss_ctl.emit       = (col_r != '0);
      iss_ctl.last_col   = at_last_col;
      iss_ctl.run_end    = !frame_last;
      iss_ctl.eof        = 1'b0;
    end
  end

  assign wr_addr   = MEM_AW'(slot_r) * MEM_AW'(MAX_SIZE) + MEM_AW'(col_r);
  assign rd_addr_a = MEM_AW'(rd_slot_a) * MEM_AW'(MAX_SIZE) + MEM_AW'(rd_col);
  assign rd_addr_b = MEM_AW'(rd_slot_b) * MEM_AW'(MAX_SIZE) + MEM_AW'(rd_col);

  // Line store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr_addr] <= in_pixel;
    end
    if (issue) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  // Column payload travels beside the store read.
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_ctl_r   <= iss_ctl;
      s1_pix_r   <= iss_pix;
      s1_use_b_r <= iss_use_b;
    end
  end

  // Position counters and sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= FS_STREAM;
      row_r      <= '0;
      col_r      <= '0;
      slot_r     <= '0;
      fl_col_r   <= '0;
      fl_slot_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      slot_r     <= slot_nxt;
      fl_col_r   <= fl_col_nxt;
      fl_slot_r  <= fl_slot_nxt;
      s1_valid_r <= issue;
    end
  end

  // Next position, flush entry and exit.
  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    slot_nxt    = slot_r;
    fl_col_nxt  = fl_col_r;
    fl_slot_nxt = fl_slot_r;
    case (state_r)
      FS_STREAM: begin
        if (accept) begin
          if (frame_last) begin
            state_nxt   = FS_FLUSH;
            fl_col_nxt  = '0;
            fl_slot_nxt = slot_r;
            row_nxt     = '0;
            col_nxt     = '0;
            slot_nxt    = '0;
          end else if (at_last_col) begin
            col_nxt  = '0;
            row_nxt  = row_r + FS_W'(1);
            slot_nxt = slot_inc(slot_r);
          end else begin
            col_nxt = col_r + FS_W'(1);
          end
        end
      end
      FS_FLUSH: begin
        if (flush_go) begin
          if (fl_last) begin
            state_nxt = FS_STREAM;
          end else begin
            fl_col_nxt = fl_col_r + FS_W'(1);
          end
        end
      end
      default: begin
        state_nxt = FS_STREAM;
      end
    endcase
    // A frame size write starts a new frame.
    if (cfg_clr) begin
      state_nxt = FS_STREAM;
      row_nxt   = '0;
      col_nxt   = '0;
      slot_nxt  = '0;
    end
  end

  // Column sum: new pixel plus the stored pixels above it.
  assign push_valid       = s1_valid_r;
  assign push_tok.ctl     = s1_ctl_r;
  assign push_tok.col_sum = COL_SUM_W'(s1_pix_r) + COL_SUM_W'(rd_a_r)
                          + (s1_use_b_r ? COL_SUM_W'(rd_b_r) : COL_SUM_W'(0));

  // The stream position always lies inside the frame.
  `BF3_ASSERT_IMPL(a_pos_in_frame, clk, rst_n, state_r == FS_STREAM, (row_r < side) && (col_r < side))
  // The last pixel of a frame starts the final-row flush.
  `BF3_ASSERT_NEXT(a_flush_entry, clk, rst_n, accept && frame_last && !cfg_clr, (state_r == FS_FLUSH) && (fl_col_r == '0))

endmodule

/* src/bf3_queue.sv */
// ----------------------------------------------------------------------------
// bf3_queue
// Short queue of column transactions between the front and the back.
// ----------------------------------------------------------------------------
`include "box_filter_3x3_edge_aware_macros.svh"

module bf3_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_valid,
  input  bf3_pkg::col_tok_t             push_tok,
  input  logic                          pop,
  output logic                          head_valid,
  output bf3_pkg::col_tok_t             head_tok,
  output logic [bf3_pkg::Q_CNT_W-1:0]   count
);
  import bf3_pkg::*;

  col_tok_t             entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  // Storage.
  always_ff @(posedge clk) begin
    if (push_valid) begin
      entries[wr_ptr_r] <= push_tok;
    end
  end

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_nxt = push_valid ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push_valid) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_tok   = entries[rd_ptr_r];
  assign count      = count_r;

  // The front reserves room, so a push never meets a full queue.
  `BF3_ASSERT_IMPL(a_no_overflow, clk, rst_n, push_valid, count_r < Q_CNT_W'(Q_DEPTH))
  // The back pops only an entry that is there.
  `BF3_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, count_r != '0)

endmodule

/* src/bf3_back.sv */
// ----------------------------------------------------------------------------
// bf3_back
// Slides a three-column window over the column transactions, forms the
// neighborhood sum and count, and divides with rounding into the output
// register.
// ----------------------------------------------------------------------------
`include "box_filter_3x3_edge_aware_macros.svh"

module bf3_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_valid,
  input  bf3_pkg::col_tok_t           head_tok,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bf3_pkg::PIX_W-1:0]   out_pixel,
  output logic                        out_last,
  output logic                        out_eof
);
  import bf3_pkg::*;

  localparam int PROD3_W = NUM_W - 2 + 10;
  localparam int PROD9_W = NUM_W - 1 + 11;

  back_phase_t            phase_r, phase_nxt;
  logic [COL_SUM_W-1:0]   win_a_r;
  logic [COL_SUM_W-1:0]   win_b_r;

  logic                   s1_valid_r;
  logic [SUM_W-1:0]       s1_sum_r;
  div_sel_t               s1_div_r;
  logic                   s1_last_r;
  logic                   s1_eof_r;

  logic                   out_valid_r;
  logic [PIX_W-1:0]       out_pix_r;
  logic                   out_last_r;
  logic                   out_eof_r;

  logic                   adv;
  logic                   ld_ok;
  logic                   s1_load;
  logic [SUM_W-1:0]       ld_sum;
  logic                   ld_cols3;
  div_sel_t               ld_div;
  logic                   ld_last;
  logic                   ld_eof;

  logic [NUM_W-1:0]       numer;
  logic [PROD3_W-1:0]     prod3;
  logic [PROD9_W-1:0]     prod9;
  logic [PIX_W-1:0]       quot;

  assign adv   = !out_valid_r || out_ready;
  assign ld_ok = !s1_valid_r || adv;

  // Window step: one result per cycle if not stalled, two for a last column.
  always_comb begin
    phase_nxt = phase_r;
    pop       = 1'b0;
    s1_load   = 1'b0;
    ld_sum    = SUM_W'(win_b_r) + SUM_W'(head_tok.col_sum);
    ld_cols3  = 1'b0;
    ld_last   = head_tok.ctl.run_end;
    ld_eof    = head_tok.ctl.eof;
    case (phase_r)
      BP_FIRST: begin
        ld_sum   = (head_tok.ctl.has_left2 ? SUM_W'(win_a_r) : SUM_W'(0))
                 + SUM_W'(win_b_r) + SUM_W'(head_tok.col_sum);
        ld_cols3 = head_tok.ctl.has_left2;
        ld_last  = head_tok.ctl.run_end && !head_tok.ctl.last_col;
        ld_eof   = 1'b0;
        if (head_valid && ld_ok) begin
          s1_load = head_tok.ctl.emit;
          if (head_tok.ctl.last_col) begin
            phase_nxt = BP_SECOND;
          end else begin
            pop = 1'b1;
          end
        end
      end
      BP_SECOND: begin
        if (head_valid && ld_ok) begin
          s1_load   = 1'b1;
          pop       = 1'b1;
          phase_nxt = BP_FIRST;
        end
      end
      default: begin
        phase_nxt = BP_FIRST;
      end
    endcase
  end

  // Neighbor count: rows times columns inside the frame.
  always_comb begin
    if (head_tok.ctl.three_rows && ld_cols3) begin
      ld_div = DIV9;
    end else if (head_tok.ctl.three_rows || ld_cols3) begin
      ld_div = DIV6;
    end else begin
      ld_div = DIV4;
    end
  end

  // Window columns shift when a column is retired.
  always_ff @(posedge clk) begin
    if (pop) begin
      win_a_r <= win_b_r;
      win_b_r <= head_tok.col_sum;
    end
    if (s1_load) begin
      s1_sum_r  <= ld_sum;
      s1_div_r  <= ld_div;
      s1_last_r <= ld_last;
      s1_eof_r  <= ld_eof;
    end
  end

  // Rounded mean: (2*sum + count) / (2*count), divisors 8, 12 and 18.
  always_comb begin
    case (s1_div_r)
      DIV9:    numer = NUM_W'({s1_sum_r, 1'b0}) + NUM_W'(9);
      DIV6:    numer = NUM_W'({s1_sum_r, 1'b0}) + NUM_W'(6);
      default: numer = NUM_W'({s1_sum_r, 1'b0}) + NUM_W'(4);
    endcase
    prod3 = PROD3_W'(numer[NUM_W-1:2]) * PROD3_W'(RECIP3);
    prod9 = PROD9_W'(numer[NUM_W-1:1]) * PROD9_W'(RECIP9);
    case (s1_div_r)
      DIV9:    quot = PIX_W'(prod9 >> RECIP9_SH);
      DIV6:    quot = PIX_W'(prod3 >> RECIP3_SH);
      default: quot = PIX_W'(numer >> 3);
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_pix_r  <= quot;
      out_last_r <= s1_last_r;
      out_eof_r  <= s1_eof_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= BP_FIRST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      s1_valid_r  <= s1_load ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
      out_valid_r <= adv ? s1_valid_r : out_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pix_r;
  assign out_last  = out_last_r;
  assign out_eof   = out_eof_r;

  // The right-edge result is made from a last column still at the head.
  `BF3_ASSERT_IMPL(a_second_has_col, clk, rst_n, phase_r == BP_SECOND, head_valid && head_tok.ctl.last_col)
  // The frame end always closes a run.
  `BF3_ASSERT_IMPL(a_eof_is_last, clk, rst_n, out_valid_r && out_eof_r, out_last_r)

endmodule

/* src/box_filter_3x3_edge_aware.sv */
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_aware
// 3x3 mean filter over a square 8-bit frame in raster order; only pixels
// inside the frame count, and the mean is rounded half up.
//
//   channel   handshake            payload
//   in        in_valid/in_ready    in_pixel_in
//   out       out_valid/out_ready  out_pixel_out, out_last_of_run,
//                                  out_end_of_frame
//   config    psel/penable/pwrite  paddr, pwdata, prdata (frame_size at 0)
//
// One pixel is taken per cycle while in_ready is high. Results leave one row
// behind; the back end retires one column per cycle while the output is not
// stalled, and the last column of a row yields two results. After the last
// pixel of a frame the front reads the final row out of the line store;
// in_ready is low during that flush. A four-entry column queue lets the
// front keep accepting while the output register waits on out_ready.
// Reset is synchronous and active low; the line store is not cleared.
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_aware #(
  parameter int MAX_SIZE = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Pixel input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bf3_pkg::PIX_W-1:0]      in_pixel_in,
  // Result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bf3_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                           out_last_of_run,
  output logic                           out_end_of_frame,
  // Configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bf3_pkg::ADDR_W-1:0]     paddr,
  input  logic [bf3_pkg::PDATA_W-1:0]    pwdata,
  output logic [bf3_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import bf3_pkg::*;

  logic [FS_W-1:0]     frame_size_r, frame_size_nxt;
  logic [FS_W-1:0]     side_r, side_nxt;
  logic                cfg_wr;
  logic [FS_W-1:0]     wr_val;

  logic                push_valid;
  col_tok_t            push_tok;
  logic                pop;
  logic                head_valid;
  col_tok_t            head_tok;
  logic [Q_CNT_W-1:0]  q_count;

  // Frame size register; the clamped side is kept beside it.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[2] == REG_IDX_FRAME_SIZE);
  assign wr_val = pwdata[FS_W-1:0];

  always_comb begin
    frame_size_nxt = frame_size_r;
    side_nxt       = side_r;
    if (cfg_wr) begin
      frame_size_nxt = wr_val;
      if (wr_val < FS_W'(MIN_SIZE)) begin
        side_nxt = FS_W'(MIN_SIZE);
      end else if (wr_val > FS_W'(MAX_SIZE)) begin
        side_nxt = FS_W'(MAX_SIZE);
      end else begin
        side_nxt = wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r <= FS_W'(MIN_SIZE);
      side_r       <= FS_W'(MIN_SIZE);
    end else begin
      frame_size_r <= frame_size_nxt;
      side_r       <= side_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_IDX_FRAME_SIZE) ? PDATA_W'(frame_size_r) : '0;

  // Front: line store and column builder.
  bf3_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_clr    (cfg_wr),
    .side       (side_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel   (in_pixel_in),
    .q_count    (q_count),
    .push_valid (push_valid),
    .push_tok   (push_tok)
  );

  // Column queue.
  bf3_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_tok   (push_tok),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .count      (q_count)
  );

  // Back: window, mean and output register.
  bf3_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pixel  (out_pixel_out),
    .out_last   (out_last_of_run),
    .out_eof    (out_end_of_frame)
  );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for the 3x3 edge-aware box filter
// Streams square frames of pixels through the filter and compares every
// smoothed pixel, run-end flag and frame-end flag with a neighborhood-mean
// predictor kept in a scoreboard. Frame size is changed between phases,
// including mid-frame and out of range; writes also go to an unused address.
// ----------------------------------------------------------------------------
module testbench;
  import bf3_pkg::*;

  localparam int MAX_SIDE      = 32;
  localparam int SETTLE_CYCLES = 2 * MAX_SIDE + 16;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 410;
  localparam int CALM_ITEMS    = 330;

  localparam logic [ADDR_W-1:0] FRAME_SIZE_ADDR =
    ADDR_W'(4 * int'(REG_IDX_FRAME_SIZE));
  localparam logic [ADDR_W-1:0] UNUSED_REG_ADDR =
    ADDR_W'(4 * (int'(REG_IDX_FRAME_SIZE) + 1));

  // One smoothed pixel as it should leave the filter.
  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             run_end;
    logic             frame_end;
  } smoothed_t;

  // Predicts the smoothed stream and checks the filter output against it.
  class smoothing_scoreboard;
    logic [FS_W-1:0]  size_reg;
    logic [PIX_W-1:0] rows [3][MAX_SIDE];
    int unsigned      row_pos;
    int unsigned      col_pos;
    smoothed_t        pending [$];
    int unsigned      errors;

    function new();
      size_reg = FS_W'(MIN_SIZE);
      row_pos  = 0;
      col_pos  = 0;
      errors   = 0;
      foreach (rows[i, j]) rows[i][j] = '0;
    endfunction

    // A frame size write also restarts the frame.
    function void set_size(logic [FS_W-1:0] value);
      size_reg = value;
      row_pos  = 0;
      col_pos  = 0;
    endfunction

    // Sizes outside the legal range are clamped.
    function int unsigned side();
      if (size_reg < MIN_SIZE) return MIN_SIZE;
      if (size_reg > MAX_SIDE) return MAX_SIDE;
      return int'(size_reg);
    endfunction

    // Rounded half-up mean over the neighbors that lie inside the frame.
    function smoothed_t window_result(int r, int c, int n);
      smoothed_t   res;
      int unsigned total;
      int unsigned cnt;
      int          rr;
      int          cc;
      total = 0;
      cnt   = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          rr = r + dr;
          cc = c + dc;
          if (rr >= 0 && cc >= 0 && rr < n && cc < n) begin
            total += rows[rr % 3][cc];
            cnt++;
          end
        end
      end
      res.pixel     = PIX_W'((2 * total + cnt) / (2 * cnt));
      res.run_end   = 1'b0;
      res.frame_end = 1'b0;
      return res;
    endfunction

    // Records one accepted pixel and queues the results it releases.
    function void note_pixel(logic [PIX_W-1:0] value);
      int unsigned n;
      int unsigned r;
      int unsigned c;
      smoothed_t   burst [$];
      smoothed_t   tail;
      n = side();
      r = row_pos;
      c = col_pos;
      if (r >= n || c >= n) begin
        r = 0;
        c = 0;
      end
      rows[r % 3][c] = value;
      if (r >= 1 && c >= 1) burst.push_back(window_result(r - 1, c - 1, n));
      if (r >= 1 && c == n - 1) burst.push_back(window_result(r - 1, n - 1, n));
      // The last pixel of the frame flushes the whole final row.
      if (r == n - 1 && c == n - 1) begin
        for (int j = 0; j < n; j++) burst.push_back(window_result(r, j, n));
        tail = burst.pop_back();
        tail.frame_end = 1'b1;
        burst.push_back(tail);
      end
      if (burst.size() > 0) begin
        tail = burst.pop_back();
        tail.run_end = 1'b1;
        burst.push_back(tail);
      end
      foreach (burst[i]) pending.push_back(burst[i]);
      c++;
      if (c >= n) begin
        c = 0;
        r++;
        if (r >= n) r = 0;
      end
      row_pos = r;
      col_pos = c;
    endfunction

    // Compares one output transaction with the oldest expectation.
    function void check_result(logic [PIX_W-1:0] pixel, logic run_end,
                               logic frame_end);
      smoothed_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: pixel_out=%0d last_of_run=%0b end_of_frame=%0b",
               pixel, run_end, frame_end);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (pixel !== want.pixel) begin
        $error("pixel_out: expected %0d, actual %0d", want.pixel, pixel);
        errors++;
      end
      if (run_end !== want.run_end) begin
        $error("last_of_run: expected %0b, actual %0b", want.run_end, run_end);
        errors++;
      end
      if (frame_end !== want.frame_end) begin
        $error("end_of_frame: expected %0b, actual %0b", want.frame_end, frame_end);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [PIX_W-1:0]   in_pixel_in;
  logic               out_valid;
  logic               out_ready;
  logic [PIX_W-1:0]   out_pixel_out;
  logic               out_last_of_run;
  logic               out_end_of_frame;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  smoothing_scoreboard sb;
  bit                  calm;
  int unsigned         in_idle_pct;
  int unsigned         out_stall_pct;
  int unsigned         quiet_cycles;

  box_filter_3x3_edge_aware #(
    .MAX_SIZE(MAX_SIDE)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pixel_in(in_pixel_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pixel_out(out_pixel_out),
    .out_last_of_run(out_last_of_run),
    .out_end_of_frame(out_end_of_frame),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Output back-pressure in random bursts.
  initial begin
    int unsigned hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0 && !calm && $urandom_range(99) < out_stall_pct)
        hold = $urandom_range(1, 14);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold = hold - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor both channels and watch for a stalled run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_pixel(in_pixel_in);
      if (out_valid && out_ready)
        sb.check_result(out_pixel_out, out_last_of_run, out_end_of_frame);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pwrite && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  // Register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == FRAME_SIZE_ADDR) sb.set_size(data[FS_W-1:0]);
  endtask

  // Offers one pixel transaction, possibly after an idle burst.
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    if (!calm && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops input, waits for every expected result, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel values lean toward the extremes now and then.
  function automatic logic [PIX_W-1:0] pick_pixel();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 20) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // Main stimulus.
  initial begin
    int unsigned random_items;
    int unsigned n;
    int unsigned count;
    int unsigned sel;
    logic [PDATA_W-1:0] data;
    bit full_size_done;
    bit over_size_done;

    sb            = new();
    calm          = 1'b0;
    in_idle_pct   = 30;
    out_stall_pct = 10;
    quiet_cycles  = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_pixel_in   = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset frame size of 2, with both pixel extremes.
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    drain();

    // A size of zero acts as the smallest frame.
    cfg_write(FRAME_SIZE_ADDR, 32'd0);
    repeat (4) send_pixel(8'd255);
    drain();

    // Full 3x3 frame of maximum pixels: corner, edge and interior divisors.
    cfg_write(FRAME_SIZE_ADDR, 32'd3);
    repeat (9) send_pixel(8'd255);
    drain();

    // A size of one acts as two; every result is the rounded mean of all four pixels.
    cfg_write(FRAME_SIZE_ADDR, 32'd1);
    send_pixel(8'd1);
    send_pixel(8'd0);
    send_pixel(8'd2);
    send_pixel(8'd0);
    drain();

    // Random phases of small frames, one run at full size and one oversize run.
    random_items   = 0;
    full_size_done = 1'b0;
    over_size_done = 1'b0;
    while (random_items < RANDOM_ITEMS || !full_size_done || !over_size_done) begin
      if (random_items >= CALM_ITEMS && full_size_done && over_size_done) begin
        calm = 1'b1;
      end else begin
        sel = $urandom_range(2);
        in_idle_pct   = (sel == 0) ? 0 : (sel == 1) ? 20 : 50;
        sel = $urandom_range(2);
        out_stall_pct = (sel == 0) ? 0 : (sel == 1) ? 5 : 25;
      end

      // A write to the unused address must leave the frame position alone.
      if ($urandom_range(99) < 15) cfg_write(UNUSED_REG_ADDR, $urandom);

      if (!full_size_done && random_items >= 150) begin
        // A few rows at the largest size, covering the far right column.
        cfg_write(FRAME_SIZE_ADDR, PDATA_W'(MAX_SIDE));
        count = $urandom_range(2 * MAX_SIDE, 3 * MAX_SIDE + 10);
        for (int k = 0; k < count; k++) send_pixel(pick_pixel());
        random_items += count;
        full_size_done = 1'b1;
      end else if (!over_size_done && random_items >= 300) begin
        cfg_write(FRAME_SIZE_ADDR, PDATA_W'($urandom_range(MAX_SIDE + 1, 63)));
        count = $urandom_range(2 * MAX_SIDE, 3 * MAX_SIDE + 10);
        for (int k = 0; k < count; k++) send_pixel(pick_pixel());
        random_items += count;
        over_size_done = 1'b1;
      end else begin
        // Usually a new size, otherwise carry on within the current frame.
        if ($urandom_range(99) < 80) begin
          sel = $urandom_range(99);
          if (sel < 10) data = PDATA_W'($urandom_range(0, 1));
          else if (sel < 20) data = PDATA_W'($urandom_range(9, 14));
          else data = PDATA_W'($urandom_range(2, 8));
          if ($urandom_range(99) < 5) data = ($urandom & ~32'h3F) | data;
          cfg_write(FRAME_SIZE_ADDR, data);
        end
        n = sb.side();
        if (n > 16) count = $urandom_range(1, 120);
        else if ($urandom_range(99) < 65) count = n * n + $urandom_range(0, n);
        else count = $urandom_range(1, n * n + n);
        for (int k = 0; k < count; k++) send_pixel(pick_pixel());
        random_items += count;
      end
      drain();
    end

    if (sb.pending.size() != 0) $error("%0d results never arrived", sb.pending.size());
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/bf3_pkg.sv
src/bf3_front.sv
src/bf3_queue.sv
src/bf3_back.sv
src/box_filter_3x3_edge_aware.sv
tb/testbench.sv
